// ----- rtl/core/chds_pkg.sv -----
// Shared types, constants and helpers for the column heat diffusion step unit.
package chds_pkg;

    localparam int TEMP_W         = 32;
    localparam int FLUX_W         = 32;
    localparam int LEVEL_W        = 6;
    localparam int LVL_CFG_W      = 7;
    localparam int RATIO_W        = 16;
    localparam int GAIN_W         = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int MAX_LEVELS_DEF = 64;

    // Stream payload widths (tdata rounded up to whole bytes).
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 1;

    // Arithmetic widths: operand magnitude, signed operand, product accumulator,
    // shifted result and the widened signed sum ahead of saturation.
    localparam int OPND_W = 36;
    localparam int MAG_W  = 35;
    localparam int HALF_W = 16;
    localparam int PROD_W = MAG_W + HALF_W;
    localparam int ACC_W  = 68;
    localparam int RES_W  = ACC_W - 16;
    localparam int SUM_W  = RES_W + 2;

    localparam logic [ACC_W-1:0] ROUND_Q16 = ACC_W'(32'h0000_8000);
    localparam logic [ACC_W-1:0] ROUND_Q24 = ACC_W'(32'h0080_0000);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LEVELS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GHOST_GAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLUX_GAIN  = 2'd3;

    localparam logic [LVL_CFG_W-1:0] LEVELS_RST = 7'd2;

    // Which scaling the shared multiplier is working on.
    typedef enum logic [1:0] {
        OP_GHOST = 2'd0,
        OP_LAP   = 2'd1,
        OP_FLUX  = 2'd2
    } t_op;

    // Which result the output register takes.
    typedef enum logic [1:0] {
        EM_NONE = 2'd0,
        EM_NEW  = 2'd1,
        EM_TOP  = 2'd2,
        EM_ONE  = 2'd3
    } t_emit;

    typedef struct packed {
        logic  capture;
        logic  load;
        logic  mul_lo;
        logic  mul_hi;
        logic  fin;
        t_op   op;
        t_emit emit;
    } t_cmd;

    typedef struct packed {
        logic k_zero;
        logic is_top;
        logic out_free;
    } t_stat;

    // Clamp a widened signed value to the signed 32-bit range.
    function automatic logic signed [TEMP_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [TEMP_W-1:0] r;
        if ((&v[SUM_W-1:TEMP_W-1]) || !(|v[SUM_W-1:TEMP_W-1])) begin
            r = v[TEMP_W-1:0];
        end else if (v[SUM_W-1]) begin
            r = {1'b1, {(TEMP_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(TEMP_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/chds_ctrl.sv -----
// Sequencer that steps each accepted level through the shared multiplier and the output register.
module chds_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  chds_pkg::t_stat      i_stat,
    output chds_pkg::t_cmd       o_cmd
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_GH_LOAD  = 16'h0002,
        S_GH_LO    = 16'h0004,
        S_GH_HI    = 16'h0008,
        S_GH_FIN   = 16'h0010,
        S_LAP_LOAD = 16'h0020,
        S_LAP_LO   = 16'h0040,
        S_LAP_HI   = 16'h0080,
        S_LAP_FIN  = 16'h0100,
        S_EMIT_NEW = 16'h0200,
        S_FX_LOAD  = 16'h0400,
        S_FX_LO    = 16'h0800,
        S_FX_HI    = 16'h1000,
        S_FX_FIN   = 16'h2000,
        S_EMIT_TOP = 16'h4000,
        S_EMIT_ONE = 16'h8000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.op   = chds_pkg::OP_GHOST;
        o_cmd.emit = chds_pkg::EM_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_stat.k_zero && i_stat.is_top) begin
                        n_state = S_EMIT_ONE;
                    end else if (i_stat.k_zero) begin
                        n_state = S_GH_LOAD;
                    end else begin
                        n_state = S_LAP_LOAD;
                    end
                end
            end
            S_GH_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_GH_LO;
            end
            S_GH_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_GH_HI;
            end
            S_GH_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_GH_FIN;
            end
            S_GH_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            S_LAP_LOAD: begin
                o_cmd.op   = chds_pkg::OP_LAP;
                o_cmd.load = 1'b1;
                n_state    = S_LAP_LO;
            end
            S_LAP_LO: begin
                o_cmd.op     = chds_pkg::OP_LAP;
                o_cmd.mul_lo = 1'b1;
                n_state      = S_LAP_HI;
            end
            S_LAP_HI: begin
                o_cmd.op     = chds_pkg::OP_LAP;
                o_cmd.mul_hi = 1'b1;
                n_state      = S_LAP_FIN;
            end
            S_LAP_FIN: begin
                o_cmd.op  = chds_pkg::OP_LAP;
                o_cmd.fin = 1'b1;
                n_state   = S_EMIT_NEW;
            end
            S_EMIT_NEW: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = chds_pkg::EM_NEW;
                    n_state    = i_stat.is_top ? S_FX_LOAD : S_IDLE;
                end
            end
            S_FX_LOAD: begin
                o_cmd.op   = chds_pkg::OP_FLUX;
                o_cmd.load = 1'b1;
                n_state    = S_FX_LO;
            end
            S_FX_LO: begin
                o_cmd.op     = chds_pkg::OP_FLUX;
                o_cmd.mul_lo = 1'b1;
                n_state      = S_FX_HI;
            end
            S_FX_HI: begin
                o_cmd.op     = chds_pkg::OP_FLUX;
                o_cmd.mul_hi = 1'b1;
                n_state      = S_FX_FIN;
            end
            S_FX_FIN: begin
                o_cmd.op  = chds_pkg::OP_FLUX;
                o_cmd.fin = 1'b1;
                n_state   = S_EMIT_TOP;
            end
            S_EMIT_TOP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = chds_pkg::EM_TOP;
                    n_state    = S_IDLE;
                end
            end
            S_EMIT_ONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = chds_pkg::EM_ONE;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/chds_dpath.sv -----
// Datapath: configuration, column window state, shared multiplier and output register.
module chds_dpath #(
    parameter int MAX_LEVELS = chds_pkg::MAX_LEVELS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  chds_pkg::t_cmd                        i_cmd,
    output chds_pkg::t_stat                       o_stat,
    input  logic [chds_pkg::IN_DATA_W-1:0]        i_in_data,
    input  logic                                  i_cfg_wr_en,
    input  logic [chds_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [chds_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic signed [chds_pkg::TEMP_W-1:0]    o_new_temp,
    output logic [chds_pkg::LEVEL_W-1:0]          o_level,
    output logic signed [chds_pkg::FLUX_W-1:0]    o_upward_flux,
    output logic                                  o_flux_valid,
    output logic                                  o_last
);

    localparam int KW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int NW = ($clog2(MAX_LEVELS + 1) > chds_pkg::LVL_CFG_W) ?
                        $clog2(MAX_LEVELS + 1) : chds_pkg::LVL_CFG_W;

    localparam int TW = chds_pkg::TEMP_W;
    localparam int OW = chds_pkg::OPND_W;

    // Configuration registers.
    logic [chds_pkg::LVL_CFG_W-1:0] r_levels;
    logic [chds_pkg::RATIO_W-1:0]   r_ratio;
    logic [chds_pkg::GAIN_W-1:0]    r_ghost_gain;
    logic [chds_pkg::GAIN_W-1:0]    r_flux_gain;

    // Column state.
    logic [KW-1:0]          r_k;
    logic [KW-1:0]          n_k;
    logic signed [TW-1:0]   r_cur, r_top, r_bflux;
    logic signed [TW-1:0]   r_wo, r_wn, r_ghost, r_prior, r_nv, r_flux;

    // Multiplier state.
    logic [chds_pkg::MAG_W-1:0] r_mag;
    logic                       r_neg;
    logic [chds_pkg::ACC_W-1:0] r_acc;

    // Output register.
    logic                   r_ov;
    logic signed [TW-1:0]   r_o_temp;
    logic [chds_pkg::LEVEL_W-1:0] r_o_level;
    logic signed [chds_pkg::FLUX_W-1:0] r_o_flux;
    logic                   r_o_fv;
    logic                   r_o_last;

    logic [NW-1:0] w_n_lv, w_n_cnt;
    logic          w_is_top, w_k_zero, w_k_one;

    always_comb begin
        w_n_lv = NW'(r_levels);
        if (w_n_lv == '0) begin
            w_n_cnt = NW'(1);
        end else if (w_n_lv > NW'(MAX_LEVELS)) begin
            w_n_cnt = NW'(MAX_LEVELS);
        end else begin
            w_n_cnt = w_n_lv;
        end
    end

    assign w_is_top = ((NW'(r_k) + NW'(1)) >= w_n_cnt);
    assign w_k_zero = (r_k == '0);
    assign w_k_one  = (r_k == KW'(1));

    assign o_stat.k_zero   = w_k_zero;
    assign o_stat.is_top   = w_is_top;
    assign o_stat.out_free = !r_ov || i_out_ready;

    // Operand selection for the three scalings.
    logic signed [OW-1:0] x_cur, x_top, x_bflux, x_wo, x_wn, x_ghost, x_prior, x_nv, x_c;
    logic signed [OW-1:0] w_opnd, w_neg_opnd;

    assign x_cur   = OW'(r_cur);
    assign x_top   = OW'(r_top);
    assign x_bflux = OW'(r_bflux);
    assign x_wo    = OW'(r_wo);
    assign x_wn    = OW'(r_wn);
    assign x_ghost = OW'(r_ghost);
    assign x_prior = OW'(r_prior);
    assign x_nv    = OW'(r_nv);
    assign x_c     = w_is_top ? x_top : x_cur;

    always_comb begin
        case (i_cmd.op)
            chds_pkg::OP_GHOST: w_opnd = x_bflux;
            chds_pkg::OP_LAP: begin
                // The bottom level sees the ghost point below it.
                if (w_k_one) begin
                    w_opnd = (x_c <<< 1) + x_ghost - (x_wn <<< 1);
                end else begin
                    w_opnd = x_wo - (x_wn <<< 1) + x_c;
                end
            end
            chds_pkg::OP_FLUX: begin
                // Second-order one-sided difference, first order for two levels.
                if (w_k_one) begin
                    w_opnd = (x_top - x_nv) <<< 1;
                end else begin
                    w_opnd = (x_top <<< 1) + x_top - (x_nv <<< 2) + x_prior;
                end
            end
            default: w_opnd = '0;
        endcase
    end

    assign w_neg_opnd = -w_opnd;

    // Gain and shared 35x16 multiplier; one half of the gain per pass.
    logic [chds_pkg::GAIN_W-1:0] w_gain;
    logic [chds_pkg::HALF_W-1:0] w_gain_half;
    logic [chds_pkg::PROD_W-1:0] w_prod;
    logic [chds_pkg::ACC_W-1:0]  w_round;

    always_comb begin
        case (i_cmd.op)
            chds_pkg::OP_GHOST: w_gain = r_ghost_gain;
            chds_pkg::OP_LAP:   w_gain = chds_pkg::GAIN_W'(r_ratio);
            chds_pkg::OP_FLUX:  w_gain = r_flux_gain;
            default:            w_gain = '0;
        endcase
    end

    assign w_gain_half = i_cmd.mul_hi ? w_gain[chds_pkg::GAIN_W-1:chds_pkg::HALF_W]
                                      : w_gain[chds_pkg::HALF_W-1:0];
    assign w_prod      = r_mag * w_gain_half;
    assign w_round     = (i_cmd.op == chds_pkg::OP_GHOST) ? chds_pkg::ROUND_Q24
                                                          : chds_pkg::ROUND_Q16;

    // Shift back, restore the sign and saturate.
    logic [chds_pkg::RES_W-1:0]         w_res;
    logic [chds_pkg::SUM_W-1:0]         w_ext;
    logic signed [chds_pkg::SUM_W-1:0]  w_sres, w_nsum, w_nflux;

    assign w_res   = (i_cmd.op == chds_pkg::OP_GHOST) ?
                     chds_pkg::RES_W'(r_acc[chds_pkg::ACC_W-1:24]) :
                     r_acc[chds_pkg::ACC_W-1:16];
    assign w_ext   = chds_pkg::SUM_W'(w_res);
    assign w_sres  = r_neg ? $signed(-w_ext) : $signed(w_ext);
    assign w_nsum  = chds_pkg::SUM_W'(r_wn) + w_sres;
    assign w_nflux = -w_sres;

    always_comb begin
        n_k = r_k;
        if (i_cmd.fin && (i_cmd.op == chds_pkg::OP_GHOST)) begin
            n_k = KW'(1);
        end else if (i_cmd.emit == chds_pkg::EM_NEW) begin
            if (!w_is_top) begin
                n_k = r_k + KW'(1);
            end
        end else if ((i_cmd.emit == chds_pkg::EM_TOP) || (i_cmd.emit == chds_pkg::EM_ONE)) begin
            n_k = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels     <= chds_pkg::LEVELS_RST;
            r_ratio      <= '0;
            r_ghost_gain <= '0;
            r_flux_gain  <= '0;
            r_k          <= '0;
            r_ov         <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_idx)
                    chds_pkg::REG_LEVELS:
                        r_levels <= i_cfg_wdata[chds_pkg::LVL_CFG_W-1:0];
                    chds_pkg::REG_RATIO:
                        r_ratio <= i_cfg_wdata[chds_pkg::RATIO_W-1:0];
                    chds_pkg::REG_GHOST_GAIN:
                        r_ghost_gain <= i_cfg_wdata;
                    chds_pkg::REG_FLUX_GAIN:
                        r_flux_gain <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_k <= n_k;
            if (i_cmd.emit != chds_pkg::EM_NONE) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cur   <= i_in_data[TW-1:0];
            r_top   <= i_in_data[2*TW-1:TW];
            r_bflux <= i_in_data[3*TW-1:2*TW];
        end
        if (i_cmd.load) begin
            r_neg <= w_opnd[OW-1];
            r_mag <= chds_pkg::MAG_W'(w_opnd[OW-1] ? w_neg_opnd : w_opnd);
        end
        if (i_cmd.mul_lo) begin
            r_acc <= chds_pkg::ACC_W'(w_prod);
        end else if (i_cmd.mul_hi) begin
            r_acc <= r_acc + {1'b0, w_prod, {chds_pkg::HALF_W{1'b0}}} + w_round;
        end
        if (i_cmd.fin) begin
            case (i_cmd.op)
                chds_pkg::OP_GHOST: begin
                    r_ghost <= chds_pkg::sat32(w_sres);
                    r_wn    <= r_cur;
                end
                chds_pkg::OP_LAP:  r_nv   <= chds_pkg::sat32(w_nsum);
                chds_pkg::OP_FLUX: r_flux <= chds_pkg::sat32(w_nflux);
                default: ;
            endcase
        end
        case (i_cmd.emit)
            chds_pkg::EM_NEW: begin
                r_o_temp  <= r_nv;
                r_o_level <= chds_pkg::LEVEL_W'(r_k - KW'(1));
                r_o_flux  <= '0;
                r_o_fv    <= 1'b0;
                r_o_last  <= 1'b0;
                if (!w_is_top) begin
                    r_prior <= r_nv;
                    r_wo    <= r_wn;
                    r_wn    <= r_cur;
                end
            end
            chds_pkg::EM_TOP: begin
                r_o_temp  <= r_top;
                r_o_level <= chds_pkg::LEVEL_W'(r_k);
                r_o_flux  <= r_flux;
                r_o_fv    <= 1'b1;
                r_o_last  <= 1'b1;
                r_prior   <= r_nv;
                r_wo      <= r_wn;
                r_wn      <= r_cur;
            end
            chds_pkg::EM_ONE: begin
                r_o_temp  <= r_top;
                r_o_level <= '0;
                r_o_flux  <= r_bflux;
                r_o_fv    <= 1'b1;
                r_o_last  <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_ov;
    assign o_new_temp    = r_o_temp;
    assign o_level       = r_o_level;
    assign o_upward_flux = r_o_flux;
    assign o_flux_valid  = r_o_fv;
    assign o_last        = r_o_last;

endmodule

// ----- rtl/core/column_heat_diffusion_step_unit.sv -----
// Top level of the column heat diffusion step unit: one explicit diffusion step per bedrock column.
//
// Channel   Direction  Transfer condition            Payload
// s_axis    in         s_axis_tvalid & s_axis_tready old level temperature, top temp, basal flux
// m_axis    out        m_axis_tvalid & m_axis_tready new temperature, level, upward flux
// cfg       in         i_cfg_wr_en                   register index and write data
//
// Levels arrive bottom first. Level 0 runs the ghost-point scaling and produces no result;
// every middle level runs the Laplacian scaling and an emit step, and the top level also works
// out the upward flux before its final emit; a single-level column goes straight to its emit.
// Each scaling uses the one shared 35x16 multiplier in two passes plus load and finish steps.
// Reset is synchronous and active low; it clears the sequencer, the level counter, the
// output valid flag and the configuration registers (levels_in_use returns to two).
// A stalled output only holds the sequencer in its emit state; the output register keeps
// its result while the next input transfer is already accepted.
module column_heat_diffusion_step_unit #(
    parameter int MAX_LEVELS = chds_pkg::MAX_LEVELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input items.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0 up: old_temp[31:0], top_temp[63:32], basal_flux[95:64].
    input  logic [chds_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // Result items.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0 up: new_temp[31:0], level[37:32], upward_flux[69:38], zero fill.
    output logic [chds_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // Fields from bit 0 up: flux_valid[0].
    output logic [chds_pkg::OUT_USER_W-1:0]     m_axis_tuser,
    output logic                                m_axis_tlast,
    // Configuration writes.
    input  logic                                i_cfg_wr_en,
    input  logic [chds_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [chds_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int PAD_W = chds_pkg::OUT_DATA_W - chds_pkg::TEMP_W - chds_pkg::LEVEL_W
                           - chds_pkg::FLUX_W;

    chds_pkg::t_cmd  w_cmd;
    chds_pkg::t_stat w_stat;

    logic signed [chds_pkg::TEMP_W-1:0] w_new_temp;
    logic [chds_pkg::LEVEL_W-1:0]       w_level;
    logic signed [chds_pkg::FLUX_W-1:0] w_upward_flux;
    logic                               w_flux_valid;

    // The sequencer decides which step runs each cycle.
    chds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the column window, the multiplier and the output register.
    chds_dpath #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_in_data     (s_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_new_temp    (w_new_temp),
        .o_level       (w_level),
        .o_upward_flux (w_upward_flux),
        .o_flux_valid  (w_flux_valid),
        .o_last        (m_axis_tlast)
    );

    // Pack the result fields with the first field in the lowest bits.
    assign m_axis_tdata = {{PAD_W{1'b0}}, w_upward_flux, w_level, w_new_temp};
    assign m_axis_tuser = w_flux_valid;

`ifndef SYNTHESIS
    // A result is only written into the output register when the slot is free.
    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit != chds_pkg::EM_NONE) |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result written over a pending output transfer");

    // After an input transfer the unit is busy with that level.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a level is still in work");

    // The flux is marked valid on exactly the column's final result.
    a_flux_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] == m_axis_tlast))
        else $error("flux_valid and tlast disagree");
`endif

endmodule
